/* src/skt_pkg.sv */
// Shared types and codes for the sorted key table.
package skt_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam logic [6:0] TABLE_SIZE_RESET = 7'd64;

    localparam logic [2:0] REQ_ADD        = 3'd0;
    localparam logic [2:0] REQ_LOOKUP     = 3'd1;
    localparam logic [2:0] REQ_READ_POS   = 3'd2;
    localparam logic [2:0] REQ_REMOVE_KEY = 3'd3;
    localparam logic [2:0] REQ_REMOVE_OLD = 3'd4;
    localparam logic [2:0] REQ_REMOVE_MIN = 3'd5;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_REPLACED = 3'd1;
    localparam logic [2:0] ST_EVICTED  = 3'd2;
    localparam logic [2:0] ST_FOUND    = 3'd3;
    localparam logic [2:0] ST_MISS     = 3'd4;
    localparam logic [2:0] ST_REMOVED  = 3'd5;
    localparam logic [2:0] ST_EMPTY    = 3'd6;

    typedef struct packed {
        logic signed [31:0] key;
        logic [31:0]        rec_number;
        logic signed [31:0] stamp;
    } t_rec;

endpackage

/* src/sorted_key_table_min_evict.sv */
// Sorted key table with smallest-record-number eviction, sequenced over one memory.
//
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_stall    | i_req_type, i_key, i_rec_number,
//          |           |                            | i_stamp, i_position, i_age_limit
//  out     | output    | o_out_valid / i_out_stall  | o_status, o_out_key, o_out_rec_number,
//          |           |                            | o_out_stamp, o_removed_count, o_entry_count
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_data (table_size)
//
// The shortest requests are an unknown type and a removal from an empty table; the longest
// is an evicting add, which runs a key search, a minimum pass, a compaction pass and an
// insertion pass; each pass reads one entry a cycle through the single read port of
// the record memory.
// Reset is synchronous and active low; it clears the entry count and sets the table size
// to 64.
// The input is stalled while a request is in progress; a finished result waits in the
// output register while the next request may already be taken.
module sorted_key_table_min_evict
    import skt_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_req_type,
    input  logic signed [31:0] i_key,
    input  logic [31:0]        i_rec_number,
    input  logic signed [31:0] i_stamp,
    input  logic [5:0]         i_position,
    input  logic signed [31:0] i_age_limit,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_out_key,
    output logic [31:0]        o_out_rec_number,
    output logic signed [31:0] o_out_stamp,
    output logic [6:0]         o_removed_count,
    output logic [6:0]         o_entry_count,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [6:0]         i_cfg_data
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_FIND    = 3'd1;
    localparam logic [2:0] S_MIN     = 3'd2;
    localparam logic [2:0] S_COMPACT = 3'd3;
    localparam logic [2:0] S_INSERT  = 3'd4;
    localparam logic [2:0] S_READ    = 3'd5;
    localparam logic [2:0] S_READW   = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    localparam logic [1:0] M_KEY = 2'd0;
    localparam logic [1:0] M_IDX = 2'd1;
    localparam logic [1:0] M_AGE = 2'd2;

    t_rec mem [CAPACITY];

    logic [2:0]         r_state;
    logic [1:0]         r_mode;
    logic [6:0]         r_table_size;
    logic [CW-1:0]      r_held;
    logic [CW-1:0]      r_idx;
    logic [CW-1:0]      r_dpos;
    logic [CW-1:0]      r_wr;
    logic               r_dv;
    t_rec               r_dat;
    logic [2:0]         r_req;
    t_rec               r_in;
    logic [5:0]         r_pos;
    logic signed [31:0] r_lim;
    logic               r_hit;
    logic [IW-1:0]      r_hit_pos;
    t_rec               r_orec;
    logic [2:0]         r_status;
    logic [CW-1:0]      r_removed;

    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    t_rec               wr_data;
    logic               pass_end;
    logic               skip;
    logic               stop_now;
    logic [CW-1:0]      dpos1;
    logic [CW-1:0]      idx_m1;
    logic [31:0]        limit32;
    logic [31:0]        ts32;
    logic [31:0]        held32;
    logic [31:0]        rem32;

    assign ts32    = 32'(r_table_size);
    assign limit32 = (ts32 == 32'd0) ? 32'd1 :
                     (ts32 > 32'(CAPACITY)) ? 32'(CAPACITY) : ts32;
    assign held32  = 32'(r_held);
    assign rem32   = 32'(r_removed);
    assign dpos1   = r_dpos + 1'b1;
    assign idx_m1  = r_idx - 1'b1;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        unique case (r_mode)
            M_KEY:   skip = (r_dat.key == r_in.key);
            M_IDX:   skip = (r_dpos[IW-1:0] == r_hit_pos);
            M_AGE:   skip = (r_dat.stamp < r_lim);
            default: skip = 1'b0;
        endcase
    end

    // The insertion walks down from the top; it stops at the first smaller key.
    assign stop_now = r_dv && !(r_dat.key > r_in.key);

    always_comb begin
        rd_en    = 1'b0;
        rd_addr  = r_idx[IW-1:0];
        wr_en    = 1'b0;
        wr_addr  = r_wr[IW-1:0];
        wr_data  = r_dat;
        pass_end = (r_idx == r_held) && !r_dv;
        unique case (r_state)
            S_FIND, S_MIN: begin
                rd_en = (r_idx < r_held);
                if (r_state == S_FIND && pass_end && r_req == REQ_ADD && r_hit) begin
                    wr_en   = 1'b1;
                    wr_addr = r_hit_pos;
                    wr_data = r_in;
                end
            end
            S_COMPACT: begin
                rd_en = (r_idx < r_held);
                if (r_dv && !skip) begin
                    wr_en = 1'b1;
                end
            end
            S_INSERT: begin
                pass_end = (r_idx == '0) && !r_dv;
                rd_en    = (r_idx != '0) && !stop_now;
                rd_addr  = idx_m1[IW-1:0];
                if (r_dv) begin
                    wr_en   = 1'b1;
                    wr_addr = dpos1[IW-1:0];
                    wr_data = stop_now ? r_in : r_dat;
                end else if (pass_end) begin
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    wr_data = r_in;
                end
            end
            S_READ: begin
                rd_en   = (32'(r_pos) < held32);
                rd_addr = IW'(r_pos);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_dat <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_held       <= '0;
            r_table_size <= TABLE_SIZE_RESET;
            r_dv         <= 1'b0;
            o_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_table_size <= i_cfg_data;
            end
            if (o_out_valid && !i_out_stall && r_state != S_DONE) begin
                o_out_valid <= 1'b0;
            end

            // Read pipeline bookkeeping shared by every pass.
            r_dv <= rd_en && (r_state != S_READ);
            if (rd_en) begin
                r_dpos <= (r_state == S_INSERT) ? idx_m1 : r_idx;
                r_idx  <= (r_state == S_INSERT) ? idx_m1 : r_idx + 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req      <= i_req_type;
                        r_in.key   <= i_key;
                        r_in.rec_number <= i_rec_number;
                        r_in.stamp <= i_stamp;
                        r_pos      <= i_position;
                        r_lim      <= i_age_limit;
                        r_orec     <= '0;
                        r_hit      <= 1'b0;
                        r_hit_pos  <= '0;
                        r_removed  <= '0;
                        r_idx      <= '0;
                        r_wr       <= '0;
                        r_status   <= ST_MISS;
                        priority case (1'b1)
                            i_req_type == REQ_ADD || i_req_type == REQ_LOOKUP:
                                r_state <= S_FIND;
                            i_req_type == REQ_READ_POS:
                                r_state <= S_READ;
                            i_req_type == REQ_REMOVE_KEY || i_req_type == REQ_REMOVE_OLD
                                || i_req_type == REQ_REMOVE_MIN: begin
                                if (r_held == '0) begin
                                    r_status <= ST_EMPTY;
                                    r_state  <= S_DONE;
                                end else if (i_req_type == REQ_REMOVE_MIN) begin
                                    r_state <= S_MIN;
                                end else begin
                                    r_mode  <= (i_req_type == REQ_REMOVE_KEY) ? M_KEY : M_AGE;
                                    r_state <= S_COMPACT;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_FIND: begin
                    if (r_dv && r_dat.key == r_in.key) begin
                        r_hit     <= 1'b1;
                        r_hit_pos <= r_dpos[IW-1:0];
                        r_orec    <= r_dat;
                    end
                    if (pass_end) begin
                        r_idx <= '0;
                        if (r_req == REQ_LOOKUP) begin
                            r_status <= r_hit ? ST_FOUND : ST_MISS;
                            r_state  <= S_DONE;
                        end else if (r_hit) begin
                            r_status <= ST_REPLACED;
                            r_state  <= S_DONE;
                        end else if (held32 >= limit32) begin
                            r_state <= S_MIN;
                        end else begin
                            r_idx    <= r_held;
                            r_status <= ST_INSERTED;
                            r_state  <= S_INSERT;
                        end
                    end
                end
                S_MIN: begin
                    if (r_dv && (r_dpos == '0 || r_dat.rec_number < r_orec.rec_number)) begin
                        r_hit_pos <= r_dpos[IW-1:0];
                        r_orec    <= r_dat;
                    end
                    if (pass_end) begin
                        r_idx   <= '0;
                        r_wr    <= '0;
                        r_mode  <= M_IDX;
                        r_state <= S_COMPACT;
                    end
                end
                S_COMPACT: begin
                    if (r_dv) begin
                        if (skip) begin
                            r_hit <= 1'b1;
                            if (r_mode == M_KEY) begin
                                r_orec <= r_dat;
                            end
                        end else begin
                            r_wr <= r_wr + 1'b1;
                        end
                    end
                    if (pass_end) begin
                        r_held <= r_wr;
                        if (r_req == REQ_ADD) begin
                            r_idx    <= r_wr;
                            r_status <= ST_EVICTED;
                            r_state  <= S_INSERT;
                        end else begin
                            if (r_req == REQ_REMOVE_OLD) begin
                                r_removed <= r_held - r_wr;
                            end
                            r_status <= (r_req == REQ_REMOVE_KEY && !r_hit) ? ST_MISS
                                                                             : ST_REMOVED;
                            r_state  <= S_DONE;
                        end
                    end
                end
                S_INSERT: begin
                    if (stop_now || pass_end) begin
                        r_held  <= r_held + 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_READ: begin
                    r_state <= rd_en ? S_READW : S_DONE;
                end
                S_READW: begin
                    r_orec   <= r_dat;
                    r_status <= ST_FOUND;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (!o_out_valid || !i_out_stall) begin
                        o_out_valid      <= 1'b1;
                        o_status         <= r_status;
                        o_out_key        <= r_orec.key;
                        o_out_rec_number <= r_orec.rec_number;
                        o_out_stamp      <= r_orec.stamp;
                        o_removed_count  <= rem32[6:0];
                        o_entry_count    <= held32[6:0];
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        held32 <= 32'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMPACT && r_dv) |-> (r_wr <= r_dpos))
        else $error("compaction write overtook its read");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INSERT && (stop_now || pass_end)) |=> (r_held == $past(r_held) + 1'b1))
        else $error("insertion did not grow the table by one");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> o_in_stall)
        else $error("accepted request did not stall the input");

endmodule

/* dv/tb.sv */
// Self-checking testbench for the sorted key table with smallest-record-number eviction.
`timescale 1ns / 100ps

module tb;
    import skt_pkg::*;

    localparam int CAP = DEFAULT_CAPACITY;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 3 * CAP + 40;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] key;
        logic [31:0]        rec_number;
        logic signed [31:0] stamp;
        logic [5:0]         position;
        logic signed [31:0] age_limit;
    } t_request;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] key;
        logic [31:0]        rec_number;
        logic signed [31:0] stamp;
        logic [6:0]         removed_count;
        logic [6:0]         entry_count;
    } t_result;

    // Mirror of the table contents; works out the result of every accepted request.
    class t_table_scoreboard;
        logic signed [31:0] keys[CAP];
        logic [31:0]        recs[CAP];
        logic signed [31:0] stamps[CAP];
        int                 held;
        logic [6:0]         size_reg;
        t_result            expected_results[$];
        int                 mismatches;

        function new();
            held = 0;
            size_reg = TABLE_SIZE_RESET;
            mismatches = 0;
        endfunction

        function int find_key(logic signed [31:0] k);
            for (int i = 0; i < held; i++)
                if (keys[i] == k) return i;
            return -1;
        endfunction

        function int oldest_rec_pos();
            int loc;
            loc = 0;
            for (int i = 1; i < held; i++)
                if (recs[i] < recs[loc]) loc = i;
            return loc;
        endfunction

        function void drop_at(int loc);
            for (int i = loc; i + 1 < held; i++) begin
                keys[i] = keys[i + 1];
                recs[i] = recs[i + 1];
                stamps[i] = stamps[i + 1];
            end
            held--;
        endfunction

        function void place_sorted(t_request q);
            int loc;
            loc = 0;
            while (loc < held && keys[loc] < q.key) loc++;
            for (int i = held; i > loc; i--) begin
                keys[i] = keys[i - 1];
                recs[i] = recs[i - 1];
                stamps[i] = stamps[i - 1];
            end
            keys[loc] = q.key;
            recs[loc] = q.rec_number;
            stamps[loc] = q.stamp;
            held++;
        endfunction

        function void load_rec(ref t_result r, input int i);
            r.key = keys[i];
            r.rec_number = recs[i];
            r.stamp = stamps[i];
        endfunction

        function void note_request(t_request q);
            t_result r;
            int      limit;
            int      f;
            int      i;
            r = '0;
            r.status = ST_MISS;
            limit = size_reg;
            if (limit < 1) limit = 1;
            if (limit > CAP) limit = CAP;
            case (q.req_type)
                REQ_ADD: begin
                    f = find_key(q.key);
                    if (f >= 0) begin
                        load_rec(r, f);
                        recs[f] = q.rec_number;
                        stamps[f] = q.stamp;
                        r.status = ST_REPLACED;
                    end else if (held >= limit) begin
                        f = oldest_rec_pos();
                        load_rec(r, f);
                        drop_at(f);
                        place_sorted(q);
                        r.status = ST_EVICTED;
                    end else begin
                        place_sorted(q);
                        r.status = ST_INSERTED;
                    end
                end
                REQ_LOOKUP: begin
                    f = find_key(q.key);
                    if (f >= 0) begin
                        load_rec(r, f);
                        r.status = ST_FOUND;
                    end
                end
                REQ_READ_POS: begin
                    if (q.position < held) begin
                        load_rec(r, q.position);
                        r.status = ST_FOUND;
                    end
                end
                REQ_REMOVE_KEY: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        f = find_key(q.key);
                        if (f >= 0) begin
                            load_rec(r, f);
                            drop_at(f);
                            r.status = ST_REMOVED;
                        end
                    end
                end
                REQ_REMOVE_OLD: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        i = held;
                        while (i > 0) begin
                            i--;
                            if (stamps[i] < q.age_limit) begin
                                drop_at(i);
                                r.removed_count++;
                            end
                        end
                        r.status = ST_REMOVED;
                    end
                end
                REQ_REMOVE_MIN: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        f = oldest_rec_pos();
                        load_rec(r, f);
                        drop_at(f);
                        r.status = ST_REMOVED;
                    end
                end
                default: ;
            endcase
            r.entry_count = 7'(held);
            expected_results.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d key %0d", got.status, got.key);
                return;
            end
            want = expected_results.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch at %0t", $time);
                    $display("  exp: st %0d key %0d rec %0d stamp %0d removed %0d count %0d",
                             want.status, want.key, want.rec_number, want.stamp,
                             want.removed_count, want.entry_count);
                    $display("  got: st %0d key %0d rec %0d stamp %0d removed %0d count %0d",
                             got.status, got.key, got.rec_number, got.stamp,
                             got.removed_count, got.entry_count);
                end
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [2:0]         i_req_type;
    logic signed [31:0] i_key;
    logic [31:0]        i_rec_number;
    logic signed [31:0] i_stamp;
    logic [5:0]         i_position;
    logic signed [31:0] i_age_limit;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [2:0]         o_status;
    logic signed [31:0] o_out_key;
    logic [31:0]        o_out_rec_number;
    logic signed [31:0] o_out_stamp;
    logic [6:0]         o_removed_count;
    logic [6:0]         o_entry_count;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [6:0]         i_cfg_data;

    sorted_key_table_min_evict uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_req_type(i_req_type), .i_key(i_key), .i_rec_number(i_rec_number),
        .i_stamp(i_stamp), .i_position(i_position), .i_age_limit(i_age_limit),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_status(o_status), .o_out_key(o_out_key), .o_out_rec_number(o_out_rec_number),
        .o_out_stamp(o_out_stamp), .o_removed_count(o_removed_count),
        .o_entry_count(o_entry_count),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    t_table_scoreboard  sb;
    logic signed [31:0] key_pool[96];
    int                 hold_request;
    bit                 no_idle;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_req_type = '0;
        i_key = '0;
        i_rec_number = '0;
        i_stamp = '0;
        i_position = '0;
        i_age_limit = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
    end

    function automatic int gap_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Receiver: checks accepted results and stalls at random, or for a long
    // stretch when the stimulus asks for one.
    initial begin
        int hold_left;
        hold_left = 0;
        hold_request = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall)
                sb.check_result({o_status, o_out_key, o_out_rec_number, o_out_stamp,
                                 o_removed_count, o_entry_count});
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (no_idle) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < 25);
                if ($urandom_range(0, 199) == 0) hold_left = $urandom_range(10, 60);
            end
        end
    end

    // Ends the run when nothing moves on any channel for too long.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", quiet);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic send_request(t_request q);
        int gap;
        i_in_valid <= 1'b1;
        i_req_type <= q.req_type;
        i_key <= q.key;
        i_rec_number <= q.rec_number;
        i_stamp <= q.stamp;
        i_position <= q.position;
        i_age_limit <= q.age_limit;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(q);
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_fields(logic [2:0] t, logic signed [31:0] k, logic [31:0] rn,
                               logic signed [31:0] st, logic [5:0] p, logic signed [31:0] lim);
        t_request q;
        q = {t, k, rn, st, p, lim};
        send_request(q);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_table_size(logic [6:0] v);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.size_reg = v;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_stamp();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return $signed($urandom_range(0, 2000)) - 1000;
    endfunction

    function automatic t_request random_request();
        t_request q;
        int       w;
        w = $urandom_range(0, 99);
        if (w < 45) q.req_type = REQ_ADD;
        else if (w < 57) q.req_type = REQ_LOOKUP;
        else if (w < 67) q.req_type = REQ_READ_POS;
        else if (w < 80) q.req_type = REQ_REMOVE_KEY;
        else if (w < 84) q.req_type = REQ_REMOVE_OLD;
        else if (w < 97) q.req_type = REQ_REMOVE_MIN;
        else q.req_type = 3'($urandom_range(6, 7));
        if ($urandom_range(0, 4) == 0) q.key = $urandom;
        else q.key = key_pool[$urandom_range(0, 95)];
        if ($urandom_range(0, 4) == 0) q.rec_number = $urandom_range(0, 3);
        else q.rec_number = $urandom;
        q.stamp = rand_stamp();
        q.position = 6'($urandom_range(0, 63));
        w = $urandom_range(0, 19);
        if (w == 0) q.age_limit = 32'sh8000_0000;
        else if (w == 1) q.age_limit = 32'sh7fff_ffff;
        else q.age_limit = $signed($urandom_range(0, 400)) - 1000;
        return q;
    endfunction

    initial begin
        logic [6:0] sizes[7];
        sb = new();
        sizes = '{7'd64, 7'd5, 7'd0, 7'd1, 7'd127, 7'd16, 7'd64};
        no_idle = 1'b0;
        for (int i = 0; i < 96; i++) key_pool[i] = $urandom;
        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7fff_ffff;
        key_pool[2] = 0;
        key_pool[3] = -1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty-table answers, extremes, replacement, misses and unknown types.
        send_fields(REQ_REMOVE_KEY, 5, 0, 0, 0, 0);
        send_fields(REQ_REMOVE_OLD, 0, 0, 0, 0, 32'sh7fff_ffff);
        send_fields(REQ_REMOVE_MIN, 0, 0, 0, 0, 0);
        send_fields(REQ_READ_POS, 0, 0, 0, 0, 0);
        send_fields(REQ_ADD, 32'sh7fff_ffff, 32'hffff_ffff, 32'sh7fff_ffff, 6'd63, 0);
        send_fields(REQ_ADD, 32'sh8000_0000, 0, 32'sh8000_0000, 0, 0);
        send_fields(REQ_ADD, 0, 5, 0, 0, 0);
        send_fields(REQ_ADD, 0, 7, 12, 0, 0);
        send_fields(REQ_LOOKUP, 32'sh8000_0000, 0, 0, 0, 0);
        send_fields(REQ_LOOKUP, 123, 0, 0, 0, 0);
        send_fields(REQ_READ_POS, 0, 0, 0, 6'd2, 0);
        send_fields(REQ_READ_POS, 0, 0, 0, 6'd63, 0);
        send_fields(3'd6, 0, 0, 0, 0, 0);
        send_fields(3'd7, -1, 32'hffff_ffff, -1, 6'd63, -1);
        // Equal smallest record numbers: the lower position must go first.
        send_fields(REQ_ADD, -5, 0, 3, 0, 0);
        send_fields(REQ_REMOVE_MIN, 0, 0, 0, 0, 0);
        send_fields(REQ_REMOVE_KEY, 32'sh7fff_ffff, 0, 0, 0, 0);
        send_fields(REQ_REMOVE_KEY, 99, 0, 0, 0, 0);
        send_fields(REQ_REMOVE_OLD, 0, 0, 0, 0, 32'sh8000_0000);
        send_fields(REQ_REMOVE_OLD, 0, 0, 0, 0, 32'sh7fff_ffff);
        send_fields(REQ_LOOKUP, 0, 0, 0, 0, 0);

        for (int ph = 0; ph < 7; ph++) begin
            write_table_size(sizes[ph]);
            for (int n = 0; n < 250; n++) begin
                if (n == 100) no_idle = 1'b1;
                if (n == 140) no_idle = 1'b0;
                if (ph == 0 && n == 60) hold_request = 400;
                if (ph == 1 && n == 120) wait_drained();
                send_request(random_request());
            end
            // Fill the table before the size is lowered below the held count.
            if (ph == 0)
                for (int n = 0; n < 70; n++)
                    send_fields(REQ_ADD, key_pool[n], $urandom, rand_stamp(), 0, 0);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/skt_pkg.sv
src/sorted_key_table_min_evict.sv
dv/tb.sv
